@@ sv/tgad_pkg.sv @@
package tgad_pkg;

  // Default depth of the queue between the byte parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_TRUNCATED = 3'd0;
  localparam logic [2:0] ERR_COLOR_MAP = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ERR_BAD_DEPTH = 3'd3;
  localparam logic [2:0] ERR_RIGHT_TO_LEFT = 3'd4;

  // Image types and header constants.
  localparam logic [7:0] TYPE_RAW_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] DESC_RIGHT_TO_LEFT = 8'h10;

  // Header byte offsets.
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP      = 5'd1;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  // One classified result waiting for the output stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] pix;        // pixel bytes as stored: B in [7:0], G, R, A in [31:24]
    logic        alpha_sel;  // 1 when the pixel carries its own alpha byte
    logic [7:0]  run_len;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  err_code;
    logic        last;
  } tgad_rec_t;

endpackage

@@ sv/tgad_front.sv @@
module tgad_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tgad_pkg::tgad_rec_t q_rec_o
);
  import tgad_pkg::*;

  // Parser phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_PKT    = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  id_left_q, id_left_d;
  logic [7:0]  type_q, type_d;
  logic        bpp_sel_q, bpp_sel_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] pixels_left_q, pixels_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [31:0] pix_q, pix_d;
  logic [1:0]  pix_idx_q, pix_idx_d;
  logic        err_valid_q, err_valid_d;
  logic [2:0]  err_code_q, err_code_d;

  logic        accept;
  logic        fin;
  logic        do_finish;
  logic        do_err;
  logic [2:0]  do_err_code;
  logic        rearm;
  logic        fid_pl_zero;
  logic        rle;
  logic [31:0] pix_n;
  logic [1:0]  pix_idx_n;
  logic [7:0]  n_raw;
  logic [7:0]  n_run;
  logic [31:0] pl_n;
  logic [7:0]  pkt_left_n;
  logic [7:0]  id_left_n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fin        = final_byte_i;
  assign rle        = (type_q == TYPE_RLE_TRUECOLOR);

  // Datapath pieces for a pixel byte.
  assign pix_n     = pix_q | (32'(data_byte_i) << {pix_idx_q, 3'b000});
  assign pix_idx_n = pix_idx_q + 2'd1;
  assign n_raw     = (rle && pkt_run_q) ? pkt_left_q : 8'd1;
  assign n_run     = (32'(n_raw) > pixels_left_q) ? pixels_left_q[7:0] : n_raw;
  assign pl_n      = pixels_left_q - 32'(n_run);
  assign pkt_left_n = pkt_left_q - n_run;
  assign id_left_n = id_left_q - 8'd1;

  // Whether the image is empty when the ID field ends.
  assign fid_pl_zero = (phase_q == PH_HEADER) ? ((width_q == 16'd0) || (height_q == 16'd0))
                                              : (pixels_left_q == 32'd0);

  // Next state and result for one accepted byte.
  always_comb begin
    phase_d       = phase_q;
    hdr_cnt_d     = hdr_cnt_q;
    id_left_d     = id_left_q;
    type_d        = type_q;
    bpp_sel_d     = bpp_sel_q;
    width_d       = width_q;
    height_d      = height_q;
    pixels_left_d = pixels_left_q;
    pkt_run_d     = pkt_run_q;
    pkt_left_d    = pkt_left_q;
    pix_d         = pix_q;
    pix_idx_d     = pix_idx_q;
    err_valid_d   = err_valid_q;
    err_code_d    = err_code_q;
    do_finish     = 1'b0;
    do_err        = 1'b0;
    do_err_code   = ERR_TRUNCATED;
    rearm         = 1'b0;
    q_push_o      = 1'b0;
    q_rec_o       = '0;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          case (hdr_cnt_q)
            HDR_ID_LEN: id_left_d = data_byte_i;
            HDR_CMAP: begin
              if (data_byte_i != 8'd0 && !err_valid_d) begin
                err_valid_d = 1'b1;
                err_code_d  = ERR_COLOR_MAP;
              end
            end
            HDR_TYPE: begin
              type_d = data_byte_i;
              if (!(data_byte_i inside {TYPE_RAW_TRUECOLOR, TYPE_RLE_TRUECOLOR}) &&
                  !err_valid_d) begin
                err_valid_d = 1'b1;
                err_code_d  = ERR_BAD_TYPE;
              end
            end
            HDR_WIDTH_LO:  width_d[7:0]   = data_byte_i;
            HDR_WIDTH_HI:  width_d[15:8]  = data_byte_i;
            HDR_HEIGHT_LO: height_d[7:0]  = data_byte_i;
            HDR_HEIGHT_HI: height_d[15:8] = data_byte_i;
            HDR_DEPTH: begin
              bpp_sel_d = (data_byte_i == DEPTH_32);
              if (!(data_byte_i inside {DEPTH_24, DEPTH_32}) && !err_valid_d) begin
                err_valid_d = 1'b1;
                err_code_d  = ERR_BAD_DEPTH;
              end
            end
            HDR_DESC: begin
              if ((data_byte_i & DESC_RIGHT_TO_LEFT) != 8'd0 && !err_valid_d) begin
                err_valid_d = 1'b1;
                err_code_d  = ERR_RIGHT_TO_LEFT;
              end
            end
            default: ;
          endcase
          if (hdr_cnt_q != HDR_DESC) begin
            hdr_cnt_d = hdr_cnt_q + 5'd1;
            if (fin) begin
              do_err = 1'b1;
            end
          end else begin
            hdr_cnt_d = 5'd0;
            if (err_valid_d) begin
              do_err      = 1'b1;
              do_err_code = err_code_d;
            end else begin
              pixels_left_d = 32'(width_q) * 32'(height_q);
              if (id_left_q != 8'd0) begin
                if (fin) begin
                  do_err = 1'b1;
                end else begin
                  phase_d = PH_ID;
                end
              end else begin
                do_finish = 1'b1;
              end
            end
          end
        end
        PH_ID: begin
          id_left_d = id_left_n;
          if (id_left_n == 8'd0) begin
            do_finish = 1'b1;
          end else if (fin) begin
            do_err = 1'b1;
          end
        end
        PH_PKT: begin
          pkt_run_d  = data_byte_i[7];
          pkt_left_d = {1'b0, data_byte_i[6:0]} + 8'd1;
          pix_idx_d  = 2'd0;
          pix_d      = 32'd0;
          phase_d    = PH_PIXEL;
          if (fin) begin
            do_err = 1'b1;
          end
        end
        PH_PIXEL: begin
          if (pix_idx_n != 2'd0 && (bpp_sel_q || pix_idx_n != 2'd3)) begin
            // Pixel still incomplete.
            pix_d     = pix_n;
            pix_idx_d = pix_idx_n;
            if (fin) begin
              do_err = 1'b1;
            end
          end else begin
            pix_idx_d     = 2'd0;
            pixels_left_d = pl_n;
            if (rle) begin
              pkt_left_d = pkt_left_n;
            end
            if (pl_n != 32'd0 && fin) begin
              do_err = 1'b1;
            end else begin
              q_push_o          = 1'b1;
              q_rec_o.kind      = KIND_PIXEL;
              q_rec_o.pix       = pix_n;
              q_rec_o.alpha_sel = bpp_sel_q;
              q_rec_o.run_len   = n_run;
              pix_d             = 32'd0;
              if (pl_n == 32'd0) begin
                q_rec_o.last = 1'b1;
                if (fin) begin
                  rearm = 1'b1;
                end else begin
                  phase_d = PH_DONE;
                end
              end else if (rle && pkt_left_n == 8'd0) begin
                phase_d = PH_PKT;
              end
            end
          end
        end
        default: begin
          if (fin) begin
            rearm = 1'b1;
          end
        end
      endcase

      // End of the ID field: report the header or a truncation.
      if (do_finish) begin
        if (fin && !fid_pl_zero) begin
          do_err = 1'b1;
        end else begin
          q_push_o       = 1'b1;
          q_rec_o.kind   = KIND_HEADER;
          q_rec_o.width  = width_q;
          q_rec_o.height = height_q;
          q_rec_o.last   = fid_pl_zero;
          if (fid_pl_zero) begin
            if (fin) begin
              rearm = 1'b1;
            end else begin
              phase_d = PH_DONE;
            end
          end else begin
            pix_idx_d = 2'd0;
            pix_d     = 32'd0;
            phase_d   = rle ? PH_PKT : PH_PIXEL;
          end
        end
      end

      // Error result; the final byte rearms, otherwise trailing bytes are dropped.
      if (do_err) begin
        q_push_o         = 1'b1;
        q_rec_o          = '0;
        q_rec_o.kind     = KIND_ERROR;
        q_rec_o.err_code = do_err_code;
        q_rec_o.last     = 1'b1;
        if (fin) begin
          rearm = 1'b1;
        end else begin
          phase_d = PH_DONE;
        end
      end
    end

    // Rearm returns every register to its reset value.
    if (rearm) begin
      phase_d       = PH_HEADER;
      hdr_cnt_d     = 5'd0;
      id_left_d     = 8'd0;
      type_d        = 8'd0;
      bpp_sel_d     = 1'b0;
      width_d       = 16'd0;
      height_d      = 16'd0;
      pixels_left_d = 32'd0;
      pkt_run_d     = 1'b0;
      pkt_left_d    = 8'd0;
      pix_d         = 32'd0;
      pix_idx_d     = 2'd0;
      err_valid_d   = 1'b0;
      err_code_d    = 3'd0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEADER;
      hdr_cnt_q     <= 5'd0;
      id_left_q     <= 8'd0;
      type_q        <= 8'd0;
      bpp_sel_q     <= 1'b0;
      width_q       <= 16'd0;
      height_q      <= 16'd0;
      pixels_left_q <= 32'd0;
      pkt_run_q     <= 1'b0;
      pkt_left_q    <= 8'd0;
      pix_q         <= 32'd0;
      pix_idx_q     <= 2'd0;
      err_valid_q   <= 1'b0;
      err_code_q    <= 3'd0;
    end else begin
      phase_q       <= phase_d;
      hdr_cnt_q     <= hdr_cnt_d;
      id_left_q     <= id_left_d;
      type_q        <= type_d;
      bpp_sel_q     <= bpp_sel_d;
      width_q       <= width_d;
      height_q      <= height_d;
      pixels_left_q <= pixels_left_d;
      pkt_run_q     <= pkt_run_d;
      pkt_left_q    <= pkt_left_d;
      pix_q         <= pix_d;
      pix_idx_q     <= pix_idx_d;
      err_valid_q   <= err_valid_d;
      err_code_q    <= err_code_d;
    end
  end

endmodule

@@ sv/tgad_queue.sv @@
module tgad_queue #(
  parameter int unsigned Depth = tgad_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tgad_pkg::tgad_rec_t push_rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tgad_pkg::tgad_rec_t pop_rec_o
);
  import tgad_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tgad_rec_t       entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = entry_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

@@ sv/tgad_back.sv @@
module tgad_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  tgad_pkg::tgad_rec_t q_rec_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic [7:0]          run_length_o,
  output logic [15:0]         width_o,
  output logic [15:0]         height_o,
  output logic [2:0]          error_code_o,
  output logic                last_o
);
  import tgad_pkg::*;

  logic        valid_q, valid_d;
  logic        take;
  logic [1:0]  kind_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q, run_q;
  logic [15:0] width_q, height_q;
  logic [2:0]  err_q;
  logic        last_q;
  logic        is_pix;
  logic        is_hdr;
  logic        is_err;

  // The output register loads whenever it is empty or being taken.
  assign take    = !valid_q || out_ready_i;
  assign q_pop_o = take && !q_empty_i;
  assign valid_d = take ? !q_empty_i : valid_q;

  assign is_pix = (q_rec_i.kind == KIND_PIXEL);
  assign is_hdr = (q_rec_i.kind == KIND_HEADER);
  assign is_err = (q_rec_i.kind == KIND_ERROR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Swap stored B,G,R(,A) to R,G,B,A and clear fields that do not apply.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q   <= q_rec_i.kind;
      red_q    <= is_pix ? q_rec_i.pix[23:16] : 8'd0;
      green_q  <= is_pix ? q_rec_i.pix[15:8] : 8'd0;
      blue_q   <= is_pix ? q_rec_i.pix[7:0] : 8'd0;
      alpha_q  <= !is_pix ? 8'd0 : (q_rec_i.alpha_sel ? q_rec_i.pix[31:24] : ALPHA_OPAQUE);
      run_q    <= is_pix ? q_rec_i.run_len : 8'd0;
      width_q  <= is_hdr ? q_rec_i.width : 16'd0;
      height_q <= is_hdr ? q_rec_i.height : 16'd0;
      err_q    <= is_err ? q_rec_i.err_code : 3'd0;
      last_q   <= q_rec_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign alpha_o      = alpha_q;
  assign run_length_o = run_q;
  assign width_o      = width_q;
  assign height_o     = height_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

endmodule

@@ sv/tga_truecolor_rle_decoder.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  data_byte_i, final_byte_i
// result    out        out_valid_o/out_ready_i kind_o, red_o, green_o, blue_o, alpha_o,
//                                             run_length_o, width_o, height_o,
//                                             error_code_o, last_o
//
// One byte is accepted per cycle while the queue is not full; each byte gives at most one result.
// A result is written into the queue at the edge that accepts its byte, and the
// output register loads it from the queue whenever that register is empty or being taken.
// The parser stalls only when the queue is full; the output side drains it
// independently. The image size product is one 16x16 multiply per header.
// Reset returns the parser to the start of a header and empties the queue.
module tga_truecolor_rle_decoder #(
  parameter int unsigned QueueDepth = tgad_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  run_length_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import tgad_pkg::*;

  tgad_rec_t push_rec;
  tgad_rec_t pop_rec;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  // Byte parser and classifier.
  tgad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_rec_o      (push_rec)
  );

  // Result queue between the two sides.
  tgad_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_rec_o  (pop_rec)
  );

  // Output formatting and register.
  tgad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_rec_i      (pop_rec),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .run_length_o (run_length_o),
    .width_o      (width_o),
    .height_o     (height_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tgad_pkg::*;

  localparam int unsigned HEADER_LEN   = 18;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 860;

  localparam logic [7:0] PKT_RUN_BIT        = 8'h80;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_ID_SKIP,
    ST_PACKET,
    ST_PIXEL,
    ST_DONE
  } parse_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  error_code;
    logic        last;
  } tga_result_t;

  // Clock, reset and the signals around the block.
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data  = 8'd0;
  logic        in_final = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [7:0]  out_run_length;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [2:0]  out_error_code;
  logic        out_last;

  // Stimulus and checking bookkeeping.
  tga_result_t expected_results[$];
  logic [7:0]  file_bytes[$];
  int unsigned failures           = 0;
  int unsigned decoded_items      = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests      = 0;
  int unsigned holds_seen         = 0;
  int unsigned hold_left          = 0;
  int unsigned quiet_cycles       = 0;

  // Predicted decoder state.
  parse_state_e dec_state;
  logic [4:0]   hdr_count;
  logic [7:0]   id_left;
  logic [7:0]   img_type;
  logic         four_bytes;
  logic [15:0]  img_width;
  logic [15:0]  img_height;
  logic [31:0]  pix_left;
  logic         pkt_run;
  logic [7:0]   pkt_left;
  logic [31:0]  pix_word;
  logic [1:0]   pix_idx;
  logic         fault_seen;
  logic [2:0]   fault_code;

  tga_truecolor_rle_decoder i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (in_data),
    .final_byte_i (in_final),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (out_kind),
    .red_o        (out_red),
    .green_o      (out_green),
    .blue_o       (out_blue),
    .alpha_o      (out_alpha),
    .run_length_o (out_run_length),
    .width_o      (out_width),
    .height_o     (out_height),
    .error_code_o (out_error_code),
    .last_o       (out_last)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Return to the start of a header and forget everything about the image.
  task automatic clear_parser();
    dec_state  = ST_HEADER;
    hdr_count  = '0;
    id_left    = '0;
    img_type   = '0;
    four_bytes = 1'b0;
    img_width  = '0;
    img_height = '0;
    pix_left   = '0;
    pkt_run    = 1'b0;
    pkt_left   = '0;
    pix_word   = '0;
    pix_idx    = '0;
    fault_seen = 1'b0;
    fault_code = '0;
  endtask

  // Only the first header fault is kept.
  task automatic note_fault(input logic [2:0] code);
    if (!fault_seen) begin
      fault_seen = 1'b1;
      fault_code = code;
    end
  endtask

  // The final byte rearms; otherwise trailing bytes are ignored until it comes.
  task automatic finish_image(input logic fin);
    if (fin) begin
      clear_parser();
    end else begin
      dec_state = ST_DONE;
    end
  endtask

  task automatic raise_error(input logic [2:0] code, input logic fin);
    tga_result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    expected_results.push_back(r);
    finish_image(fin);
  endtask

  // Header info goes out once the ID field is behind us.
  task automatic close_id(input logic fin);
    tga_result_t r;
    if (fin && pix_left != 0) begin
      raise_error(ERR_TRUNCATED, 1'b1);
    end else begin
      r        = '0;
      r.kind   = KIND_HEADER;
      r.width  = img_width;
      r.height = img_height;
      r.last   = (pix_left == 0);
      expected_results.push_back(r);
      if (pix_left == 0) begin
        finish_image(fin);
      end else begin
        pix_idx   = '0;
        pix_word  = '0;
        dec_state = (img_type == TYPE_RLE_TRUECOLOR) ? ST_PACKET : ST_PIXEL;
      end
    end
  endtask

  // Advance the predicted decoder by one file byte.
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [4:0]  idx;
    logic [31:0] n;
    int unsigned need;
    logic        rle;
    tga_result_t r;
    case (dec_state)
      ST_HEADER: begin
        idx = hdr_count;
        case (idx)
          HDR_ID_LEN: id_left = b;
          HDR_CMAP: if (b != 8'd0) note_fault(ERR_COLOR_MAP);
          HDR_TYPE: begin
            img_type = b;
            if (b != TYPE_RAW_TRUECOLOR && b != TYPE_RLE_TRUECOLOR) note_fault(ERR_BAD_TYPE);
          end
          HDR_WIDTH_LO:  img_width[7:0]   = b;
          HDR_WIDTH_HI:  img_width[15:8]  = b;
          HDR_HEIGHT_LO: img_height[7:0]  = b;
          HDR_HEIGHT_HI: img_height[15:8] = b;
          HDR_DEPTH: begin
            four_bytes = (b == DEPTH_32);
            if (b != DEPTH_24 && b != DEPTH_32) note_fault(ERR_BAD_DEPTH);
          end
          HDR_DESC: if ((b & DESC_RIGHT_TO_LEFT) != 8'd0) note_fault(ERR_RIGHT_TO_LEFT);
          default: ;
        endcase
        if (idx + 1 < HEADER_LEN) begin
          hdr_count = idx + 5'd1;
          if (fin) raise_error(ERR_TRUNCATED, 1'b1);
        end else begin
          hdr_count = '0;
          if (fault_seen) begin
            raise_error(fault_code, fin);
          end else begin
            pix_left = 32'(img_width) * 32'(img_height);
            if (id_left != 0) begin
              if (fin) begin
                raise_error(ERR_TRUNCATED, 1'b1);
              end else begin
                dec_state = ST_ID_SKIP;
              end
            end else begin
              close_id(fin);
            end
          end
        end
      end
      ST_ID_SKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) begin
          close_id(fin);
        end else if (fin) begin
          raise_error(ERR_TRUNCATED, 1'b1);
        end
      end
      ST_PACKET: begin
        pkt_run   = b[7];
        pkt_left  = {1'b0, b[6:0]} + 8'd1;
        pix_idx   = '0;
        pix_word  = '0;
        dec_state = ST_PIXEL;
        if (fin) raise_error(ERR_TRUNCATED, 1'b1);
      end
      ST_PIXEL: begin
        need     = four_bytes ? 4 : 3;
        n        = 32'd1;
        rle      = (img_type == TYPE_RLE_TRUECOLOR);
        pix_word = pix_word | (32'(b) << (8 * pix_idx));
        pix_idx  = pix_idx + 2'd1;
        if (pix_idx != 0 && pix_idx < need) begin
          if (fin) raise_error(ERR_TRUNCATED, 1'b1);
        end else begin
          // A complete pixel: a run packet covers its whole count, clipped.
          pix_idx = '0;
          if (rle && pkt_run) n = 32'(pkt_left);
          if (n > pix_left) n = pix_left;
          pix_left = pix_left - n;
          if (rle) pkt_left = pkt_left - n[7:0];
          if (pix_left != 0 && fin) begin
            raise_error(ERR_TRUNCATED, 1'b1);
          end else begin
            r            = '0;
            r.kind       = KIND_PIXEL;
            r.red        = pix_word[23:16];
            r.green      = pix_word[15:8];
            r.blue       = pix_word[7:0];
            r.alpha      = four_bytes ? pix_word[31:24] : ALPHA_OPAQUE;
            r.run_length = n[7:0];
            r.last       = (pix_left == 0);
            expected_results.push_back(r);
            pix_word = '0;
            if (pix_left == 0) begin
              finish_image(fin);
            end else if (rle && pkt_left == 0) begin
              dec_state = ST_PACKET;
            end
          end
        end
      end
      default: begin
        if (fin) clear_parser();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it, and wait for the transaction.
  task automatic send_byte(input logic [7:0] value, input logic last_byte);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= value;
    in_final <= last_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decoded_items++;
    decode_byte(value, last_byte);
  endtask

  // Send the assembled file, marking its last byte as final.
  task automatic send_file();
    int unsigned n;
    int unsigned i;
    n = file_bytes.size();
    for (i = 0; i < n; i++) begin
      send_byte(file_bytes[i], i == n - 1);
    end
    file_bytes.delete();
  endtask

  task automatic add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] itype, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth,
                            input logic [7:0] desc);
    file_bytes.push_back(id_len);
    file_bytes.push_back(cmap);
    file_bytes.push_back(itype);
    repeat (9) file_bytes.push_back(8'($urandom));
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(desc);
    repeat (int'(id_len)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_pixels(input int unsigned count, input logic four);
    repeat (count * (four ? 4 : 3)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_junk(input int unsigned count);
    repeat (count) file_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_file(input int unsigned keep);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
  endtask

  // Packets of random kind and size until the image is covered.
  task automatic add_rle_body(input int unsigned total, input logic four,
                              input int unsigned long_pct);
    int   remaining;
    int   c;
    logic run;
    remaining = int'(total);
    while (remaining > 0) begin
      c   = ($urandom_range(99) < long_pct) ? int'($urandom_range(1, 128))
                                            : int'($urandom_range(1, 6));
      run = 1'($urandom_range(0, 1));
      file_bytes.push_back({run, 7'(c - 1)});
      if (run) begin
        add_pixels(1, four);
      end else begin
        add_pixels(32'((c < remaining) ? c : remaining), four);
      end
      remaining -= c;
    end
  endtask

  // Mostly well-formed images with random content, some damaged, some noise.
  task automatic random_file();
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  itype;
    logic [7:0]  depth;
    logic [7:0]  desc;
    logic [15:0] w;
    logic [15:0] h;
    logic        four;
    if ($urandom_range(99) < 6) begin
      add_junk($urandom_range(1, 40));
    end else begin
      if ($urandom_range(99) < 70) begin
        id_len = 8'd0;
      end else if ($urandom_range(99) < 5) begin
        id_len = 8'hFF;
      end else begin
        id_len = 8'($urandom_range(1, 6));
      end
      cmap = ($urandom_range(99) < 95) ? 8'd0 : 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 92) begin
        itype = ($urandom_range(99) < 65) ? TYPE_RLE_TRUECOLOR : TYPE_RAW_TRUECOLOR;
      end else begin
        itype = 8'($urandom);
      end
      if ($urandom_range(99) < 93) begin
        depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      end else begin
        depth = 8'($urandom);
      end
      desc = 8'($urandom);
      if ($urandom_range(99) < 90) desc = desc & ~DESC_RIGHT_TO_LEFT;
      if ($urandom_range(99) < 5) begin
        // Empty image with one large dimension.
        w = 16'($urandom);
        h = 16'd0;
        if ($urandom_range(0, 1)) begin
          h = w;
          w = 16'd0;
        end
      end else begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 4));
      end
      four = (depth == DEPTH_32);
      add_header(id_len, cmap, itype, w, h, depth, desc);
      if (itype == TYPE_RLE_TRUECOLOR) begin
        add_rle_body(32'(w) * 32'(h), four, 15);
      end else begin
        add_pixels(32'(w) * 32'(h), four);
      end
      if ($urandom_range(99) < 12) begin
        cut_file($urandom_range(1, file_bytes.size()));
      end else if ($urandom_range(99) < 15) begin
        add_junk($urandom_range(1, 4));
      end
    end
    send_file();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Uncompressed images of both depths, with extreme channel values.
  task automatic test_raw_truecolor();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd2, 16'd1, DEPTH_24, 8'h00);
    repeat (3) file_bytes.push_back(8'h00);
    repeat (3) file_bytes.push_back(8'hFF);
    send_file();
    add_header(8'd3, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, DEPTH_32, 8'h20);
    file_bytes.push_back(8'h11);
    file_bytes.push_back(8'h22);
    file_bytes.push_back(8'h33);
    file_bytes.push_back(8'h44);
    send_file();
  endtask

  // Run and raw packets, clipping of a long run, an exact 128 run, raw overrun.
  task automatic test_rle_truecolor();
    add_header(8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd5, 16'd2, DEPTH_32, 8'h08);
    file_bytes.push_back(PKT_RUN_BIT | 8'd2);
    add_pixels(1, 1'b1);
    file_bytes.push_back(8'h01);
    add_pixels(2, 1'b1);
    file_bytes.push_back(8'hFF);
    add_pixels(1, 1'b1);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd128, 16'd1, DEPTH_24, 8'h00);
    file_bytes.push_back(8'hFF);
    add_pixels(1, 1'b0);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd2, 16'd1, DEPTH_24, 8'h00);
    file_bytes.push_back(8'h7F);
    add_pixels(2, 1'b0);
    add_junk(4);
    send_file();
  endtask

  // Each header fault, their priority, and a fault on the final byte.
  task automatic test_header_faults();
    add_header(8'd0, 8'h01, 8'h03, 16'd1, 16'd1, 8'd16, DESC_RIGHT_TO_LEFT);
    add_junk(3);
    send_file();
    add_header(8'd0, 8'd0, 8'hFF, 16'd1, 16'd1, 8'd8, 8'h00);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, 8'd16, 8'h00);
    add_pixels(1, 1'b0);
    send_file();
    add_header(8'd2, 8'd0, TYPE_RLE_TRUECOLOR, 16'd1, 16'd1, DEPTH_32, 8'hFF);
    send_file();
    add_header(8'd0, 8'hFF, TYPE_RAW_TRUECOLOR, 16'd0, 16'd0, DEPTH_24, 8'h00);
    send_file();
  endtask

  // Images without pixels: header info closes them, with a long ID field too.
  task automatic test_empty_images();
    add_header(8'hFF, 8'd0, TYPE_RLE_TRUECOLOR, 16'hFFFF, 16'd0, DEPTH_32, 8'h00);
    add_junk(2);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd0, 16'hFFFF, DEPTH_24, 8'h00);
    send_file();
  endtask

  // Final byte arriving early in every phase of the file.
  task automatic test_truncation();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00);
    cut_file(5);
    send_file();
    add_header(8'd4, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00);
    cut_file(20);
    send_file();
    add_header(8'd4, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00);
    send_file();
    add_header(8'd1, 8'd0, TYPE_RAW_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00);
    cut_file(HEADER_LEN);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00);
    file_bytes.push_back(PKT_RUN_BIT | 8'd3);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd2, 16'd1, DEPTH_32, 8'h00);
    add_pixels(1, 1'b1);
    add_junk(2);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd2, 16'd1, DEPTH_24, 8'h00);
    add_pixels(1, 1'b0);
    send_file();
    add_header(8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_24, 8'h00);
    file_bytes.push_back(8'hFF);
    add_pixels(1, 1'b0);
    file_bytes.push_back(8'hFF);
    add_pixels(1, 1'b0);
    send_file();
  endtask

  // The receiver holds off while a long raw image keeps coming in.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    add_header(8'd0, 8'd0, TYPE_RAW_TRUECOLOR, 16'd64, 16'd1, DEPTH_24, 8'h00);
    add_pixels(64, 1'b0);
    send_file();
  endtask

  // Random files under each mix of sender idling and receiver stalls.
  task automatic test_random_files();
    int unsigned mode;
    int unsigned goal;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
      endcase
      goal = decoded_items + RANDOM_ITEMS / 4;
      while (decoded_items < goal) random_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checking and watchdog
  // ---------------------------------------------------------------------------

  // Random stalls, plus long hold-offs counted here on request.
  always @(posedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic note_failure(input string msg);
    failures++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      note_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    tga_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result of kind %0d with nothing expected", out_kind));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(out_kind), 32'(want.kind));
        check_field("red", 32'(out_red), 32'(want.red));
        check_field("green", 32'(out_green), 32'(want.green));
        check_field("blue", 32'(out_blue), 32'(want.blue));
        check_field("alpha", 32'(out_alpha), 32'(want.alpha));
        check_field("run_length", 32'(out_run_length), 32'(want.run_length));
        check_field("width", 32'(out_width), 32'(want.width));
        check_field("height", 32'(out_height), 32'(want.height));
        check_field("error_code", 32'(out_error_code), 32'(want.error_code));
        check_field("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // End the run when no transaction happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tga_truecolor_rle_decoder regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_raw_truecolor();
    test_rle_truecolor();
    test_header_faults();
    test_empty_images();
    test_truncation();
    test_backpressure();
    test_random_files();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tga_truecolor_rle_decoder regression: pass");
    end else begin
      $display("tga_truecolor_rle_decoder regression: fail");
    end
    $finish;
  end

endmodule
